// ----- rtl/fet_pkg.sv -----
// ============================================================================
// fet_pkg
// Shared number format, codes, command/status types and saturating
// fixed-point helpers for the escape-time fractal iterator.
// ============================================================================
package fet_pkg;

    localparam int FRAC_BITS  = 24;
    localparam int COORD_BITS = 12;
    localparam int W_BITS     = FRAC_BITS + 8;
    localparam int MUL_W      = (W_BITS > 32) ? W_BITS : 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int WIDE_W     = MUL_W + 2;
    localparam int CNT_W      = 16;
    localparam int STEP_W     = 31;
    localparam int CFG_W      = 32;
    localparam int MODE_W     = 3;
    localparam int IDX_W      = 3;

    typedef logic signed [W_BITS-1:0] t_work;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [MUL_W-1:0]  t_mop;
    typedef logic        [PROD_W-1:0] t_prod;

    localparam t_work VMAX   = {1'b0, {(W_BITS-1){1'b1}}};
    localparam t_work VMIN   = {1'b1, {(W_BITS-1){1'b0}}};
    localparam t_work ZERO   = '0;
    localparam t_wide WMAX   = t_wide'(VMAX);
    localparam t_wide WMIN   = t_wide'(VMIN);
    localparam t_prod CAP    = t_prod'(1) << (W_BITS - 1);
    localparam t_work THRESH = t_work'(64'd16 << FRAC_BITS);
    localparam t_work QUARTER = t_work'(64'd1 << (FRAC_BITS - 2));
    localparam t_work C29    = t_work'(((64'd29 << FRAC_BITS) + 64'd50) / 64'd100);
    localparam t_work C02    = t_work'(((64'd2 << FRAC_BITS) + 64'd50) / 64'd100);

    // recurrence select
    localparam logic [MODE_W-1:0] MODE_JULIA   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MANDEL  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_VARIANT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SHIFTED = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CONJ    = 3'd4;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_MODE   = 3'd0;
    localparam logic [IDX_W-1:0] CFG_STEP   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_OFF_RE = 3'd2;
    localparam logic [IDX_W-1:0] CFG_OFF_IM = 3'd3;
    localparam logic [IDX_W-1:0] CFG_K_RE   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_K_IM   = 3'd5;
    localparam logic [IDX_W-1:0] CFG_LIMIT  = 3'd6;

    // multiplier operand select
    localparam logic [2:0] MUL_MX = 3'd0;
    localparam logic [2:0] MUL_MY = 3'd1;
    localparam logic [2:0] MUL_AA = 3'd2;
    localparam logic [2:0] MUL_BB = 3'd3;
    localparam logic [2:0] MUL_AB = 3'd4;

    // product write-back target
    localparam logic [2:0] WB_NONE = 3'd0;
    localparam logic [2:0] WB_PX   = 3'd1;
    localparam logic [2:0] WB_PY   = 3'd2;
    localparam logic [2:0] WB_AA   = 3'd3;
    localparam logic [2:0] WB_BB   = 3'd4;
    localparam logic [2:0] WB_AB2  = 3'd5;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [STEP_W-1:0] pixel_step;
        logic [CFG_W-1:0]  offset_re;
        logic [CFG_W-1:0]  offset_im;
        logic [CFG_W-1:0]  const_re;
        logic [CFG_W-1:0]  const_im;
        logic [CNT_W-1:0]  iter_limit;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic [2:0] mul_sel;
        logic [2:0] wb_sel;
        logic       setup;
        logic       comb1;
        logic       comb2;
        logic       iter_inc;
    } t_cmd;

    typedef struct packed {
        logic limit_zero;
        logic escaped;
        logic last;
    } t_sts;

    function automatic t_work sat_w(input t_wide v);
        if (v > WMAX) begin
            return VMAX;
        end else if (v < WMIN) begin
            return VMIN;
        end
        return t_work'(v);
    endfunction

    function automatic t_work q_add(input t_work a, input t_work b);
        return sat_w(t_wide'(a) + t_wide'(b));
    endfunction

    function automatic t_work q_sub(input t_work a, input t_work b);
        return sat_w(t_wide'(a) - t_wide'(b));
    endfunction

    // magnitude product -> fixed point, truncated toward zero, saturated
    function automatic t_work q_mul(input t_prod p, input logic neg);
        t_prod sh;
        sh = p >> FRAC_BITS;
        if (sh >= CAP) begin
            return neg ? VMIN : VMAX;
        end
        if (neg) begin
            return -t_work'(sh);
        end
        return t_work'(sh);
    endfunction

    // integer product (pixel times step), saturated
    function automatic t_work q_raw(input t_prod p);
        if (p >= CAP) begin
            return VMAX;
        end
        return t_work'(p);
    endfunction

endpackage

// ----- rtl/fet_ctrl.sv -----
// ============================================================================
// fet_ctrl
// Sequencer: steps the shared multiplier and the update logic of the
// datapath through mapping, setup and the per-iteration schedule.
// ============================================================================
module fet_ctrl
    import fet_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_done
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MX    = 4'd1;
    localparam logic [3:0] S_MY    = 4'd2;
    localparam logic [3:0] S_WPY   = 4'd3;
    localparam logic [3:0] S_SETUP = 4'd4;
    localparam logic [3:0] S_TA    = 4'd5;
    localparam logic [3:0] S_TB    = 4'd6;
    localparam logic [3:0] S_TW    = 4'd7;
    localparam logic [3:0] S_TEST  = 4'd8;
    localparam logic [3:0] S_AB    = 4'd9;
    localparam logic [3:0] S_WAB   = 4'd10;
    localparam logic [3:0] S_C1    = 4'd11;
    localparam logic [3:0] S_C2    = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] r_state, n_state;
    logic       r_first, n_first;

    always_comb begin
        n_state = r_state;
        n_first = r_first;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MX;
                end
            end
            S_MX: begin
                o_cmd.mul_sel = MUL_MX;
                n_state       = S_MY;
            end
            S_MY: begin
                o_cmd.mul_sel = MUL_MY;
                o_cmd.wb_sel  = WB_PX;
                n_state       = S_WPY;
            end
            S_WPY: begin
                o_cmd.wb_sel = WB_PY;
                n_state      = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_first     = 1'b1;
                n_state     = i_sts.limit_zero ? S_DONE : S_TA;
            end
            S_TA: begin
                o_cmd.mul_sel = MUL_AA;
                n_state       = S_TB;
            end
            S_TB: begin
                o_cmd.mul_sel = MUL_BB;
                o_cmd.wb_sel  = WB_AA;
                n_state       = S_TW;
            end
            S_TW: begin
                o_cmd.wb_sel = WB_BB;
                // squares of z0 feed the first update, no escape test on them
                n_state      = r_first ? S_AB : S_TEST;
            end
            S_TEST: begin
                if (i_sts.escaped) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.iter_inc = 1'b1;
                    n_state        = i_sts.last ? S_DONE : S_AB;
                end
            end
            S_AB: begin
                o_cmd.mul_sel = MUL_AB;
                n_first       = 1'b0;
                n_state       = S_WAB;
            end
            S_WAB: begin
                o_cmd.wb_sel = WB_AB2;
                n_state      = S_C1;
            end
            S_C1: begin
                o_cmd.comb1 = 1'b1;
                n_state     = S_C2;
            end
            S_C2: begin
                o_cmd.comb2 = 1'b1;
                n_state     = S_TA;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

// ----- rtl/fet_dpath.sv -----
// ============================================================================
// fet_dpath
// Datapath: one registered magnitude multiplier shared by mapping, the
// squarings and a*b, z/c registers, two-step saturating update, escape counter.
// ============================================================================
module fet_dpath
    import fet_pkg::*;
(
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    input  t_cfg                  i_cfg,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    output t_sts                  o_sts,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic [CNT_W-1:0]      o_iter_count
);

    logic [COORD_BITS-1:0] r_x, r_y;
    logic [CNT_W-1:0]      r_iter;
    t_work                 r_a, r_b, r_cr, r_ci;
    t_work                 r_aa, r_bb, r_ab2, r_ta, r_tb;
    t_prod                 r_prod;
    logic                  r_neg;

    logic [MODE_W-1:0] mode_eff;
    t_mop              op1, op2;
    logic [MUL_W-1:0]  mag1, mag2;
    t_work             kre, kim, ore, oim;
    t_work             p_q, ta, tb;

    assign mode_eff = (i_cfg.mode > MODE_CONJ) ? MODE_JULIA : i_cfg.mode;
    assign kre = sat_w(t_wide'(signed'(i_cfg.const_re)));
    assign kim = sat_w(t_wide'(signed'(i_cfg.const_im)));
    assign ore = sat_w(t_wide'(signed'(i_cfg.offset_re)));
    assign oim = sat_w(t_wide'(signed'(i_cfg.offset_im)));

    // multiplier operands, sign-magnitude
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_MX: begin
                op1 = t_mop'({1'b0, r_x});
                op2 = t_mop'({1'b0, i_cfg.pixel_step});
            end
            MUL_MY: begin
                op1 = t_mop'({1'b0, r_y});
                op2 = t_mop'({1'b0, i_cfg.pixel_step});
            end
            MUL_AA: begin
                op1 = t_mop'(r_a);
                op2 = t_mop'(r_a);
            end
            MUL_BB: begin
                op1 = t_mop'(r_b);
                op2 = t_mop'(r_b);
            end
            default: begin
                op1 = t_mop'(r_a);
                op2 = t_mop'(r_b);
            end
        endcase
    end

    assign mag1 = op1[MUL_W-1] ? MUL_W'(-op1) : MUL_W'(op1);
    assign mag2 = op2[MUL_W-1] ? MUL_W'(-op2) : MUL_W'(op2);
    assign p_q  = q_mul(r_prod, r_neg);

    // first half of the update
    always_comb begin
        unique case (mode_eff)
            MODE_VARIANT: begin
                ta = q_add(q_sub(r_aa, r_a), r_bb);
                tb = q_sub(r_ab2, r_b);
            end
            MODE_SHIFTED: begin
                ta = q_sub(q_sub(r_aa, r_a), r_bb);
                tb = q_add(r_b, r_ab2);
            end
            MODE_CONJ: begin
                ta = q_sub(r_aa, r_bb);
                tb = q_sub(ZERO, r_ab2);
            end
            default: begin
                ta = q_sub(r_aa, r_bb);
                tb = r_ab2;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(mag1) * PROD_W'(mag2);
        r_neg  <= op1[MUL_W-1] ^ op2[MUL_W-1];

        if (i_cmd.load) begin
            r_x    <= i_pixel_x;
            r_y    <= i_pixel_y;
            r_iter <= '0;
        end
        if (i_cmd.iter_inc) begin
            r_iter <= r_iter + CNT_W'(1);
        end

        unique case (i_cmd.wb_sel)
            WB_PX:   r_a   <= q_add(q_raw(r_prod), ore);
            WB_PY:   r_b   <= q_add(q_raw(r_prod), oim);
            WB_AA:   r_aa  <= p_q;
            WB_BB:   r_bb  <= p_q;
            WB_AB2:  r_ab2 <= q_add(p_q, p_q);
            default: ;
        endcase

        if (i_cmd.setup) begin
            if (mode_eff == MODE_MANDEL || mode_eff == MODE_VARIANT) begin
                r_cr <= q_add(r_a, kre);
                r_ci <= q_sub(q_add(r_b, kim), QUARTER);
                r_a  <= ZERO;
                r_b  <= ZERO;
            end else if (mode_eff == MODE_CONJ) begin
                r_cr <= C29;
                r_ci <= C02;
            end else begin
                r_cr <= kre;
                r_ci <= kim;
            end
        end
        if (i_cmd.comb1) begin
            r_ta <= ta;
            r_tb <= tb;
        end
        if (i_cmd.comb2) begin
            r_a <= q_add(r_ta, r_cr);
            r_b <= q_add(r_tb, r_ci);
        end
    end

    assign o_sts.limit_zero = (i_cfg.iter_limit == '0);
    assign o_sts.escaped    = (q_add(r_aa, r_bb) > THRESH);
    assign o_sts.last       = ((r_iter + CNT_W'(1)) == i_cfg.iter_limit);

    assign o_out_x      = r_x;
    assign o_out_y      = r_y;
    assign o_iter_count = r_iter;

endmodule

// ----- rtl/fractal_escape_time_iterator.sv -----
// ============================================================================
// fractal_escape_time_iterator
// The o_done strobe follows a taken start once mapping, setup and the
//   iterations are through; with a zero iteration limit setup goes to done.
// A new pixel is taken only once the last one is done; each iteration runs
//   three products on the shared 32x32 multiplier with their write-backs,
//   the escape test and the two update steps, all in sequence.
// Reset (synchronous, active low) idles the sequencer and reloads the
//   register defaults; results cannot be stalled, o_done is a one-cycle word.
// ============================================================================
module fractal_escape_time_iterator
    import fet_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_pixel_x,
    input  logic [COORD_BITS-1:0] i_pixel_y,
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    output logic                  o_done,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y,
    output logic [CNT_W-1:0]      o_iter_count
);

    // Configuration registers. They are to be written only while idle (the block
    // does not enforce it), so the datapath reads them directly during a pixel.
    logic [MODE_W-1:0] r_mode;
    logic [STEP_W-1:0] r_pixel_step;
    logic [CFG_W-1:0]  r_offset_re, r_offset_im;
    logic [CFG_W-1:0]  r_const_re, r_const_im;
    logic [CNT_W-1:0]  r_iter_limit;

    t_cfg cfg;
    t_cmd cmd;
    t_sts sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_JULIA;
            r_pixel_step <= STEP_W'(83886);
            r_offset_re  <= '0;
            r_offset_im  <= '0;
            r_const_re   <= '0;
            r_const_im   <= '0;
            r_iter_limit <= CNT_W'(50);
        end else if (i_cfg_we) begin
            // an index past the list is dropped
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode       <= i_cfg_data[MODE_W-1:0];
                CFG_STEP:   r_pixel_step <= i_cfg_data[STEP_W-1:0];
                CFG_OFF_RE: r_offset_re  <= i_cfg_data;
                CFG_OFF_IM: r_offset_im  <= i_cfg_data;
                CFG_K_RE:   r_const_re   <= i_cfg_data;
                CFG_K_IM:   r_const_im   <= i_cfg_data;
                CFG_LIMIT:  r_iter_limit <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.mode       = r_mode;
    assign cfg.pixel_step = r_pixel_step;
    assign cfg.offset_re  = r_offset_re;
    assign cfg.offset_im  = r_offset_im;
    assign cfg.const_re   = r_const_re;
    assign cfg.const_im   = r_const_im;
    assign cfg.iter_limit = r_iter_limit;

    // Sequencer: map x, map y, set up z0/c, then per iteration a*a, b*b,
    // escape test (skipped on z0), a*b, 2ab write-back, two update steps.
    fet_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // The squares taken for the escape test are reused as a*a and b*b of
    // the next iteration, so each iteration needs three products.
    fet_dpath u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_cfg        (cfg),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .o_sts        (sts),
        .o_out_x      (o_out_x),
        .o_out_y      (o_out_y),
        .o_iter_count (o_iter_count)
    );

    // result word only while a pixel is in flight
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    // a taken start keeps the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("start taken but block not busy");

    // one word per pixel
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // count never passes the limit
    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_iter_count <= r_iter_limit))
        else $error("iteration count above limit");

endmodule
